### rtl/core/ppdm_pkg.sv
// ----------------------------------------------------------------------------
// ppdm_pkg
// Shared types and constants for the periodic phase dependency map unit.
// ----------------------------------------------------------------------------
package ppdm_pkg;

    localparam int PHASE_W = 32;
    localparam int ENTRY_W = 17;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 16;
    localparam int DCNT_W  = 8;
    localparam int DIV_N_W = 31;
    localparam int DIV_D_W = 16;
    localparam int PROD_W  = 47;
    localparam int SUM_W   = 48;

    localparam logic [PHASE_W-1:0] MAX_PHASE = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_MAP_DST = 2'd1,
        MODE_MAP_SRC = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_INIT_SRC   = 2'd0,
        CFG_INIT_DST   = 2'd1,
        CFG_STEADY_SRC = 2'd2,
        CFG_STEADY_DST = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        RD_ITEM,
        RD_MID,
        RD_LOW
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_ITEM_RD,
        S_ITEM_FIN,
        S_SRCH,
        S_CMP,
        S_LAST,
        S_DONE
    } t_state;

    typedef struct packed {
        t_mode                      mode;
        logic [7:0]                 entry_index;
        logic [ENTRY_W-1:0]         entry_value;
        logic signed [PHASE_W-1:0]  phase;
    } t_in_item;

    typedef struct packed {
        logic signed [PHASE_W-1:0]  result_phase;
        logic                       early_message;
        logic                       out_of_range;
    } t_out_item;

    typedef struct packed {
        t_cfg_reg                   index;
        logic [CNT_W-1:0]           data;
    } t_cfg_item;

    typedef struct packed {
        logic       load_item;
        logic       prep;
        logic       set_special;
        logic       div_start;
        logic       take_div;
        t_rd_sel    rd_sel;
        logic       upd_bound;
        logic       fin_item;
        logic       fin_search;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic       map_dst;
        logic       special;
        logic       need_div;
        logic       div_done;
        logic       search_more;
        logic       out_free;
    } t_dp_stat;

endpackage

### rtl/core/ppdm_chan_if.sv
// ----------------------------------------------------------------------------
// ppdm_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface ppdm_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/ppdm_div.sv
// ----------------------------------------------------------------------------
// ppdm_div
// Restoring divider, one quotient bit per cycle, done pulse after last bit.
// ----------------------------------------------------------------------------
module ppdm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ppdm_pkg::DIV_N_W-1:0]    i_dividend,
    input  logic [ppdm_pkg::DIV_D_W-1:0]    i_divisor,
    output logic                            o_done,
    output logic [ppdm_pkg::DIV_N_W-1:0]    o_quot,
    output logic [ppdm_pkg::DIV_D_W-1:0]    o_rem
);
    import ppdm_pkg::*;

    localparam int CW = $clog2(DIV_N_W);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [DIV_N_W-1:0] r_q;
    logic [DIV_D_W-1:0] r_acc;
    logic [DIV_D_W-1:0] r_d;

    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               fits;
    logic [DIV_D_W-1:0] n_acc;
    logic [DIV_N_W-1:0] n_q;

    always_comb begin
        trial = {r_acc, r_q[DIV_N_W-1]};
        diff  = trial - {1'b0, r_d};
        fits  = (trial >= {1'b0, r_d});
        n_acc = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        n_q   = {r_q[DIV_N_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_acc <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_acc;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc < r_d))
        else $error("divider remainder not below divisor");

endmodule

### rtl/core/ppdm_dp.sv
// ----------------------------------------------------------------------------
// ppdm_dp
// Datapath: config registers, dependency table, divider, multiply, search
// bounds, result register.
// ----------------------------------------------------------------------------
module ppdm_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ppdm_pkg::t_dp_cmd       i_cmd,
    output ppdm_pkg::t_dp_stat      o_stat,
    input  ppdm_pkg::t_in_item      i_item,
    input  logic                    i_cfg_we,
    input  ppdm_pkg::t_cfg_item     i_cfg,
    input  logic                    i_res_ready,
    output logic                    o_res_valid,
    output ppdm_pkg::t_out_item     o_res
);
    import ppdm_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // configuration
    logic [CNT_W-1:0]   r_init_src;
    logic [DCNT_W-1:0]  r_init_dst;
    logic [CNT_W-1:0]   r_steady_src;
    logic [DCNT_W-1:0]  r_steady_dst;

    // item and working state
    t_mode              r_mode;
    logic [PHASE_W-1:0] r_phase;
    logic [IDX_W-1:0]   r_idx;
    logic [PHASE_W-1:0] r_s;
    logic [IDX_W-1:0]   r_lo;
    logic [IDX_W-1:0]   r_hi;
    logic [SUM_W-1:0]   r_add;
    logic [SUM_W-1:0]   r_sum;
    logic               r_early;
    logic               r_oor;

    // table
    logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_q;
    logic               r_rd_ok;

    // result
    logic               r_res_valid;
    t_out_item          r_res;

    logic               map_dst;
    logic [8:0]         base;
    logic [DCNT_W-1:0]  sd;
    logic [CNT_W-1:0]   ss;
    logic [17:0]        thr;
    logic [DIV_N_W-1:0] mag;
    logic [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0] div_d;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;
    logic [DIV_D_W-1:0] div_r;
    logic [CNT_W-1:0]   mf;
    logic [PROD_W-1:0]  prod;
    logic [IDX_W-1:0]   hi0;
    logic [IDX_W:0]     lohi_sum;
    logic [IDX_W-1:0]   mid;
    logic [IDX_W-1:0]   rd_idx;
    logic               rd_ok;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               sat;

    always_comb begin
        map_dst  = (r_mode == MODE_MAP_DST);
        base     = {1'b0, r_init_dst} + 9'd1;
        sd       = (r_steady_dst == '0) ? DCNT_W'(1) : r_steady_dst;
        ss       = (r_steady_src == '0) ? CNT_W'(1) : r_steady_src;
        thr      = 18'(r_init_src) + 18'(ss) + 18'd1;
        mag      = r_phase[DIV_N_W-1:0];
        div_n    = map_dst ? (mag - DIV_N_W'(base))
                           : (mag - DIV_N_W'(r_init_src) - DIV_N_W'(1));
        div_d    = map_dst ? DIV_D_W'(sd) : ss;
        mf       = map_dst ? r_steady_src : CNT_W'(r_steady_dst);
        prod     = PROD_W'(div_q) * PROD_W'(mf);
        hi0      = IDX_W'(r_init_dst) + IDX_W'(r_steady_dst);
        lohi_sum = {1'b0, r_lo} + {1'b0, r_hi};
        mid      = lohi_sum[IDX_W:1];
        case (i_cmd.rd_sel)
            RD_ITEM: rd_idx = r_idx;
            RD_MID:  rd_idx = mid;
            RD_LOW:  rd_idx = r_lo;
            default: rd_idx = r_idx;
        endcase
        rd_ok   = (32'(rd_idx) < TABLE_DEPTH);
        rd_addr = AW'(rd_idx);
        rd_data = r_rd_ok ? r_rd_q : '0;
        sat     = (r_sum > SUM_W'(MAX_PHASE));
    end

    always_comb begin
        o_stat.map_dst     = map_dst;
        o_stat.special     = map_dst ? r_phase[PHASE_W-1]
                                     : (r_phase[PHASE_W-1] || (r_phase == '0));
        o_stat.need_div    = map_dst ? (mag >= DIV_N_W'(base)) : (mag >= DIV_N_W'(thr));
        o_stat.div_done    = div_done;
        o_stat.search_more = ({1'b0, r_hi} > ({1'b0, r_lo} + (IDX_W+1)'(1)));
        o_stat.out_free    = !r_res_valid || i_res_ready;
    end

    ppdm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_src   <= '0;
            r_init_dst   <= '0;
            r_steady_src <= CNT_W'(1);
            r_steady_dst <= DCNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg.index)
                CFG_INIT_SRC:   r_init_src   <= i_cfg.data;
                CFG_INIT_DST:   r_init_dst   <= i_cfg.data[DCNT_W-1:0];
                CFG_STEADY_SRC: r_steady_src <= i_cfg.data;
                CFG_STEADY_DST: r_steady_dst <= i_cfg.data[DCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item && (i_item.mode == MODE_WRITE)
                && (32'(i_item.entry_index) < TABLE_DEPTH)) begin
            r_mem[AW'(i_item.entry_index)] <= i_item.entry_value;
        end
        r_rd_q  <= r_mem[rd_addr];
        r_rd_ok <= rd_ok;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode  <= i_item.mode;
            r_phase <= i_item.phase;
        end
        if (i_cmd.prep) begin
            r_add <= '0;
            r_idx <= IDX_W'(r_phase[7:0]);
            r_s   <= r_phase;
            r_lo  <= '0;
            r_hi  <= hi0;
        end
        if (i_cmd.take_div) begin
            r_add <= SUM_W'(prod);
            r_idx <= IDX_W'(div_r[7:0]) + IDX_W'(base);
            r_s   <= PHASE_W'(div_r) + PHASE_W'(r_init_src) + PHASE_W'(1);
        end
        if (i_cmd.upd_bound) begin
            if (PHASE_W'(rd_data) >= r_s) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid;
            end
        end
        if (i_cmd.set_special) begin
            r_sum   <= map_dst ? '0 : SUM_W'(1);
            r_early <= !map_dst;
            r_oor   <= map_dst;
        end
        if (i_cmd.fin_item) begin
            r_sum   <= SUM_W'(rd_data) + r_add;
            r_early <= 1'b0;
            r_oor   <= 1'b0;
        end
        if (i_cmd.fin_search) begin
            r_sum   <= SUM_W'((PHASE_W'(rd_data) == r_s) ? r_lo : r_hi) + r_add;
            r_early <= 1'b0;
            r_oor   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_res.result_phase  <= sat ? MAX_PHASE : r_sum[PHASE_W-1:0];
            r_res.early_message <= r_early;
            r_res.out_of_range  <= r_oor || sat;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_bound |=> (r_lo < r_hi))
        else $error("search bounds crossed");

    a_result_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !r_res.result_phase[PHASE_W-1])
        else $error("mapped phase negative");

endmodule

### rtl/core/ppdm_ctrl.sv
// ----------------------------------------------------------------------------
// ppdm_ctrl
// Sequencer: accepts items, steps division, table reads and the search.
// ----------------------------------------------------------------------------
module ppdm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ppdm_pkg::t_mode     i_in_mode,
    output logic                o_in_ready,
    input  ppdm_pkg::t_dp_stat  i_stat,
    output ppdm_pkg::t_dp_cmd   o_cmd
);
    import ppdm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_ITEM;
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
                if (i_in_valid && (i_in_mode inside {MODE_MAP_DST, MODE_MAP_SRC})) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_stat.special) begin
                    o_cmd.set_special = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (i_stat.map_dst) begin
                    n_state = S_ITEM_RD;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.take_div = 1'b1;
                n_state = i_stat.map_dst ? S_ITEM_RD : S_SRCH;
            end
            S_ITEM_RD: begin
                o_cmd.rd_sel = RD_ITEM;
                n_state = S_ITEM_FIN;
            end
            S_ITEM_FIN: begin
                o_cmd.fin_item = 1'b1;
                n_state = S_DONE;
            end
            S_SRCH: begin
                if (i_stat.search_more) begin
                    o_cmd.rd_sel = RD_MID;
                    n_state = S_CMP;
                end else begin
                    o_cmd.rd_sel = RD_LOW;
                    n_state = S_LAST;
                end
            end
            S_CMP: begin
                o_cmd.rd_sel    = RD_MID;
                o_cmd.upd_bound = 1'b1;
                n_state = S_SRCH;
            end
            S_LAST: begin
                o_cmd.fin_search = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_div_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DIV))
        else $error("divider finished outside wait state");

endmodule

### rtl/core/periodic_phase_dependency_map_unit.sv
// ----------------------------------------------------------------------------
// periodic_phase_dependency_map_unit
// Maps destination phases to source phases and back through a dependency
// table covering init phases and one steady-state period.
//
//   channel  dir  payload                                   handshake
//   i_in     in   mode, entry_index, entry_value, phase     valid/ready
//   o_res    out  result_phase, early_message, out_of_range valid/ready
//   i_cfg    in   index, data                               valid/ready (ready=1)
//
// Writes (mode 0) and unused mode 3 give no result. Mode 1 reads its table
// entry directly inside the init region and uses the divider beyond it; mode 2
// uses the 31-bit bit-serial divider when needed, then a binary search of up to
// 9 steps, each a registered table read followed by a bound update.
// Reset is synchronous; table contents are undefined until written.
// A finished result waits in the output register; the next item is accepted
// while it waits.
// ----------------------------------------------------------------------------
module periodic_phase_dependency_map_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppdm_chan_if.sink   i_in,
    ppdm_chan_if.source o_res,
    ppdm_chan_if.sink   i_cfg
);
    import ppdm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_in_item in_item;
    t_cfg_item cfg_item;
    t_out_item res_item;
    logic     in_ready;
    logic     res_valid;

    assign in_item    = i_in.payload;
    assign cfg_item   = i_cfg.payload;
    assign i_in.ready = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid   = res_valid;
    assign o_res.payload = res_item;

    ppdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (in_item.mode),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ppdm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (in_item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg       (cfg_item),
        .i_res_ready (o_res.ready),
        .o_res_valid (res_valid),
        .o_res       (res_item)
    );

endmodule
